/* src/wfma_pkg.sv */
package wfma_pkg;

    localparam int FRAME_SAMPLES = 512;
    localparam int MAX_WINDOW    = 16;
    localparam int HIST_DEPTH    = MAX_WINDOW * FRAME_SAMPLES;

    localparam int SAMPLE_W = 16;
    localparam int WIN_W    = 5;
    localparam int SUM_W    = 32;
    localparam int SPOS_W   = $clog2(FRAME_SAMPLES);
    localparam int SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int HELD_W   = $clog2(MAX_WINDOW + 2);
    localparam int HIST_AW  = $clog2(HIST_DEPTH);

    // dividend width below saturation: sum < 2^16 * window
    localparam int QX_W     = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int RECIP_K  = QX_W + HELD_W;
    localparam int RECIP_W  = RECIP_K + 1;

    localparam logic [WIN_W-1:0]    WIN_RESET  = 5'd8;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;

endpackage

/* src/wfma_div.sv */
module wfma_div (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [wfma_pkg::QX_W-1:0]           i_dividend,
    input  logic [wfma_pkg::HELD_W-1:0]         i_divisor,
    output logic [wfma_pkg::SAMPLE_W-1:0]       o_quotient
);

    localparam int TAB_N  = 2 ** wfma_pkg::HELD_W;
    localparam int PROD_W = wfma_pkg::QX_W + wfma_pkg::RECIP_W;

    logic [wfma_pkg::RECIP_W-1:0] recip_tab [TAB_N];
    logic [wfma_pkg::QX_W-1:0]    r_x;
    logic [wfma_pkg::RECIP_W-1:0] r_recip;
    logic [PROD_W-1:0]            product;

    // ceil(2^k / d) for every legal divisor
    for (genvar g = 0; g < TAB_N; g++) begin : g_recip
        if (g >= 1 && g <= wfma_pkg::MAX_WINDOW) begin : g_used
            localparam logic [wfma_pkg::RECIP_W-1:0] RC = wfma_pkg::RECIP_W'(
                ((64'd1 << wfma_pkg::RECIP_K) + 64'(g) - 64'd1) / 64'(g));
            assign recip_tab[g] = RC;
        end else begin : g_unused
            assign recip_tab[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x     <= i_dividend;
            r_recip <= recip_tab[i_divisor];
        end
    end

    assign product    = PROD_W'(r_x) * PROD_W'(r_recip);
    assign o_quotient = product[wfma_pkg::RECIP_K +: wfma_pkg::SAMPLE_W];

endmodule

/* src/waveform_frame_moving_average.sv */
// path: a sample passes stage 1, stage 2 and the output register, each able to stall
// throughput: one sample per cycle unless the output stalls; sum and history
// memories are read at accept and written one stage later, with forwarding when
// consecutive samples meet; reset: a clearing pass writes zero to all 8192 history
// entries (and sum entries alongside) with in ready low; config is taken throughout
module waveform_frame_moving_average (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wfma_pkg::WIN_W-1:0]     i_window_frames,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [wfma_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  logic                           i_frame_end,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [wfma_pkg::SAMPLE_W-1:0]  o_average_value,
    output logic                           o_window_full,
    output logic                           o_last_of_frame
);

    localparam int SLOTX_W = wfma_pkg::SLOT_W + 2;

    logic [wfma_pkg::SAMPLE_W-1:0] hist_mem [wfma_pkg::HIST_DEPTH];
    logic [wfma_pkg::SUM_W-1:0]    sum_mem  [wfma_pkg::FRAME_SAMPLES];

    logic [wfma_pkg::WIN_W-1:0]    r_win;
    logic [wfma_pkg::HELD_W-1:0]   r_held;
    logic [wfma_pkg::SLOT_W-1:0]   r_oldest;
    logic [wfma_pkg::SPOS_W-1:0]   r_pos;
    logic                          r_clearing;
    logic [wfma_pkg::HIST_AW-1:0]  r_clr;

    logic                          en1, en2, en3, accept;
    logic [wfma_pkg::HELD_W-1:0]   n_eff, count, held_after, div;
    logic                          drop, full;
    logic [SLOTX_W-1:0]            slot_sum;
    logic [wfma_pkg::SLOT_W-1:0]   new_slot, next_oldest;
    logic [wfma_pkg::HIST_AW-1:0]  rd_addr, wr_addr;

    logic                          r_s1_v;
    logic [wfma_pkg::SPOS_W-1:0]   r_s1_pos;
    logic [wfma_pkg::HIST_AW-1:0]  r_s1_waddr;
    logic [wfma_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic                          r_s1_drop, r_s1_full, r_s1_last;
    logic [wfma_pkg::HELD_W-1:0]   r_s1_div;
    logic                          r_s1_sum_hit, r_s1_hist_hit;
    logic [wfma_pkg::SUM_W-1:0]    r_sum_rd, r_wsum;
    logic [wfma_pkg::SAMPLE_W-1:0] r_hist_rd, r_whist;

    logic [wfma_pkg::SUM_W-1:0]    old_sum, n_sum;
    logic [wfma_pkg::SAMPLE_W-1:0] old_hist;
    logic                          sat;
    logic                          s1_write;

    logic                          r_s2_v, r_s2_sat, r_s2_full, r_s2_last;
    logic [wfma_pkg::SAMPLE_W-1:0] quotient;

    logic                          r_v3;
    logic [wfma_pkg::SAMPLE_W-1:0] r_avg;
    logic                          r_full3, r_last3;

    // pipeline flow control
    assign en3      = !r_v3 || i_out_ready;
    assign en2      = !r_s2_v || en3;
    assign en1      = !r_s1_v || en2;
    assign o_in_ready  = en1 && !r_clearing;
    assign accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign s1_write = r_s1_v && en2;

    // request decode against current frame state
    always_comb begin
        if (r_win == '0) begin
            n_eff = wfma_pkg::HELD_W'(1);
        end else if (32'(r_win) > wfma_pkg::MAX_WINDOW) begin
            n_eff = wfma_pkg::HELD_W'(wfma_pkg::MAX_WINDOW);
        end else begin
            n_eff = wfma_pkg::HELD_W'(r_win);
        end
        count      = r_held + wfma_pkg::HELD_W'(1);
        drop       = count > n_eff;
        held_after = drop ? r_held : count;
        div        = (held_after < n_eff) ? held_after : n_eff;
        full       = held_after == n_eff;
        slot_sum   = SLOTX_W'(r_oldest) + SLOTX_W'(r_held);
        if (32'(slot_sum) >= wfma_pkg::MAX_WINDOW) begin
            new_slot = wfma_pkg::SLOT_W'(slot_sum - SLOTX_W'(wfma_pkg::MAX_WINDOW));
        end else begin
            new_slot = wfma_pkg::SLOT_W'(slot_sum);
        end
        if (32'(r_oldest) + 1 >= wfma_pkg::MAX_WINDOW) begin
            next_oldest = '0;
        end else begin
            next_oldest = r_oldest + wfma_pkg::SLOT_W'(1);
        end
        rd_addr = wfma_pkg::HIST_AW'(32'(r_oldest) * wfma_pkg::FRAME_SAMPLES + 32'(r_pos));
        wr_addr = wfma_pkg::HIST_AW'(32'(new_slot) * wfma_pkg::FRAME_SAMPLES + 32'(r_pos));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= wfma_pkg::WIN_RESET;
            r_held     <= '0;
            r_oldest   <= '0;
            r_pos      <= '0;
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_win <= i_window_frames;
            end
            if (r_clearing) begin
                r_clr <= r_clr + wfma_pkg::HIST_AW'(1);
                if (r_clr == wfma_pkg::HIST_AW'(wfma_pkg::HIST_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept) begin
                if (i_frame_end) begin
                    r_held <= held_after;
                    if (drop) begin
                        r_oldest <= next_oldest;
                    end
                    r_pos <= '0;
                end else if (32'(r_pos) == wfma_pkg::FRAME_SAMPLES - 1) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + wfma_pkg::SPOS_W'(1);
                end
            end
        end
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            hist_mem[r_clr] <= '0;
        end else if (s1_write) begin
            hist_mem[r_s1_waddr] <= r_s1_sample;
        end
        if (accept) begin
            r_hist_rd <= hist_mem[rd_addr];
        end
    end

    // sum memory
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            if ({1'b0, r_clr} < (wfma_pkg::HIST_AW + 1)'(wfma_pkg::FRAME_SAMPLES)) begin
                sum_mem[r_clr[wfma_pkg::SPOS_W-1:0]] <= '0;
            end
        end else if (s1_write) begin
            sum_mem[r_s1_pos] <= n_sum;
        end
        if (accept) begin
            r_sum_rd <= sum_mem[r_pos];
        end
    end

    // stage 1: read-modify-write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en1) begin
            r_s1_v <= accept;
        end
        if (accept) begin
            r_s1_pos      <= r_pos;
            r_s1_waddr    <= wr_addr;
            r_s1_sample   <= i_sample_value;
            r_s1_drop     <= drop;
            r_s1_full     <= full;
            r_s1_last     <= i_frame_end;
            r_s1_div      <= div;
            r_s1_sum_hit  <= s1_write && (r_s1_pos == r_pos);
            r_s1_hist_hit <= s1_write && (r_s1_waddr == rd_addr);
        end
        if (s1_write) begin
            r_wsum  <= n_sum;
            r_whist <= r_s1_sample;
        end
    end

    always_comb begin
        old_sum  = r_s1_sum_hit ? r_wsum : r_sum_rd;
        old_hist = r_s1_hist_hit ? r_whist : r_hist_rd;
        n_sum    = old_sum + wfma_pkg::SUM_W'(r_s1_sample);
        if (r_s1_drop) begin
            n_sum = n_sum - wfma_pkg::SUM_W'(old_hist);
        end
        sat = n_sum[wfma_pkg::SUM_W-1:wfma_pkg::SAMPLE_W]
              >= (wfma_pkg::SUM_W - wfma_pkg::SAMPLE_W)'(r_s1_div);
    end

    // stage 2: reciprocal multiply
    wfma_div u_div (
        .i_clk      (i_clk),
        .i_en       (s1_write),
        .i_dividend (n_sum[wfma_pkg::QX_W-1:0]),
        .i_divisor  (r_s1_div),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en2) begin
            r_s2_v <= r_s1_v;
        end
        if (s1_write) begin
            r_s2_sat  <= sat;
            r_s2_full <= r_s1_full;
            r_s2_last <= r_s1_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_s2_v;
        end
        if (en3 && r_s2_v) begin
            r_avg   <= r_s2_sat ? wfma_pkg::SAMPLE_MAX : quotient;
            r_full3 <= r_s2_full;
            r_last3 <= r_s2_last;
        end
    end

    assign o_out_valid     = r_v3;
    assign o_average_value = r_avg;
    assign o_window_full   = r_full3;
    assign o_last_of_frame = r_last3;

endmodule

/* bench/tb_waveform_frame_moving_average.sv */
`timescale 1ns / 100ps
module tb_waveform_frame_moving_average;

    typedef struct packed {
        logic [wfma_pkg::SAMPLE_W-1:0] average;
        logic                          full;
        logic                          last;
    } t_average;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_cfg_valid     = 1'b0;
    logic [wfma_pkg::WIN_W-1:0]    i_window_frames = '0;
    logic                          i_in_valid      = 1'b0;
    logic [wfma_pkg::SAMPLE_W-1:0] i_sample_value  = '0;
    logic                          i_frame_end     = 1'b0;
    logic                          i_out_ready     = 1'b0;
    logic                          o_cfg_ready;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic [wfma_pkg::SAMPLE_W-1:0] o_average_value;
    logic                          o_window_full;
    logic                          o_last_of_frame;

    logic [wfma_pkg::SAMPLE_W-1:0] frame_history [wfma_pkg::HIST_DEPTH];
    logic [wfma_pkg::SUM_W-1:0]    position_sums [wfma_pkg::FRAME_SAMPLES];
    int                            held_frames;
    int                            oldest_slot;
    int                            next_position;
    logic [wfma_pkg::WIN_W-1:0]    window_setting;
    t_average                      pending_averages [$];
    int                            error_count = 0;
    int                            cycle_count = 0;
    bit                            calm_stretch = 1'b0;

    waveform_frame_moving_average DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_window_frames (i_window_frames),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample_value  (i_sample_value),
        .i_frame_end     (i_frame_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_average_value (o_average_value),
        .o_window_full   (o_window_full),
        .o_last_of_frame (o_last_of_frame)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= calm_stretch || ($urandom_range(0, 99) >= 29);
    end

    task automatic report_field(input string field, input int wanted, input int seen);
        $display("%0t: %s expected %0d actual %0d", $time, field, wanted, seen);
        error_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_average seen;
        t_average wanted;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = '{o_average_value, o_window_full, o_last_of_frame};
            if (pending_averages.size() == 0) begin
                $display("%0t: unexpected result average_value %0d", $time, seen.average);
                error_count++;
            end else begin
                wanted = pending_averages.pop_front();
                if (seen.average !== wanted.average)
                    report_field("average_value", wanted.average, seen.average);
                if (seen.full !== wanted.full)
                    report_field("window_full", wanted.full, seen.full);
                if (seen.last !== wanted.last)
                    report_field("last_of_frame", wanted.last, seen.last);
            end
        end
    end

    task automatic predict_average(input logic [wfma_pkg::SAMPLE_W-1:0] sample,
                                   input logic last);
        int                         span;
        int                         count;
        int                         held_after;
        int                         old_slot;
        int                         new_slot;
        bit                         drop;
        logic [wfma_pkg::SUM_W-1:0] total;
        logic [wfma_pkg::SUM_W-1:0] divisor;
        logic [wfma_pkg::SUM_W-1:0] quotient;
        t_average                   result;
        span = (window_setting == 0) ? 1 :
               (window_setting > wfma_pkg::MAX_WINDOW) ? wfma_pkg::MAX_WINDOW :
               int'(window_setting);
        count      = held_frames + 1;
        drop       = count > span;
        held_after = drop ? count - 1 : count;
        old_slot   = oldest_slot % wfma_pkg::MAX_WINDOW;
        new_slot   = (oldest_slot + held_frames) % wfma_pkg::MAX_WINDOW;
        total      = position_sums[next_position] + wfma_pkg::SUM_W'(sample);
        if (drop)
            total = total - wfma_pkg::SUM_W'(
                frame_history[old_slot * wfma_pkg::FRAME_SAMPLES + next_position]);
        frame_history[new_slot * wfma_pkg::FRAME_SAMPLES + next_position] = sample;
        position_sums[next_position] = total;
        divisor = wfma_pkg::SUM_W'((held_after < span) ? held_after : span);
        if (divisor == 0)
            divisor = 1;
        quotient       = total / divisor;
        result.average = (quotient > wfma_pkg::SUM_W'(wfma_pkg::SAMPLE_MAX)) ?
                         wfma_pkg::SAMPLE_MAX : quotient[wfma_pkg::SAMPLE_W-1:0];
        result.full    = (held_after == span);
        result.last    = last;
        pending_averages.push_back(result);
        if (last) begin
            held_frames = held_after;
            if (drop)
                oldest_slot = (old_slot + 1) % wfma_pkg::MAX_WINDOW;
            next_position = 0;
        end else begin
            next_position = (next_position + 1) % wfma_pkg::FRAME_SAMPLES;
        end
    endtask

    function automatic logic [wfma_pkg::SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return wfma_pkg::SAMPLE_MAX;
            default: return wfma_pkg::SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_sample(input logic [wfma_pkg::SAMPLE_W-1:0] sample,
                               input logic last);
        while (!calm_stretch && $urandom_range(0, 99) < 29) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= sample;
        i_frame_end    <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_average(sample, last);
    endtask

    task automatic send_frame(input int length);
        for (int k = 0; k < length; k++)
            send_sample(random_sample(), k == length - 1);
    endtask

    // hold off new requests until every average has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_averages.size() != 0);
    endtask

    task automatic write_window(input logic [wfma_pkg::WIN_W-1:0] setting);
        i_cfg_valid     <= 1'b1;
        i_window_frames <= setting;
        do @(posedge i_clk); while (!o_cfg_ready);
        window_setting = setting;
        i_cfg_valid    <= 1'b0;
    endtask

    task automatic test_reset_window();
        send_sample(16'h0000, 1'b0);
        send_sample(wfma_pkg::SAMPLE_MAX, 1'b0);
        send_sample(16'h0001, 1'b1);
        send_sample(wfma_pkg::SAMPLE_MAX, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h8000, 1'b1);
        repeat (3) send_sample(wfma_pkg::SAMPLE_MAX, 1'b0);
        send_sample(16'h5555, 1'b1);
    endtask

    task automatic test_window_extremes();
        wait_drained();
        write_window(wfma_pkg::WIN_W'(0));
        repeat (2) begin
            send_sample(16'h0007, 1'b0);
            send_sample(wfma_pkg::SAMPLE_MAX, 1'b1);
        end
        wait_drained();
        write_window('1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hAAAA, 1'b1);
        wait_drained();
        write_window(wfma_pkg::WIN_W'(wfma_pkg::MAX_WINDOW + 1));
        send_sample(wfma_pkg::SAMPLE_MAX, 1'b1);
        wait_drained();
        write_window(wfma_pkg::WIN_W'(wfma_pkg::MAX_WINDOW));
        send_sample(16'h1234, 1'b1);
    endtask

    task automatic test_window_lowered();
        wait_drained();
        write_window(wfma_pkg::WIN_W'(4));
        repeat (5) send_sample(wfma_pkg::SAMPLE_MAX, 1'b1);
        wait_drained();
        write_window(wfma_pkg::WIN_W'(1));
        repeat (3) send_sample(wfma_pkg::SAMPLE_MAX, 1'b1);
    endtask

    task automatic test_mid_frame_change();
        wait_drained();
        write_window(wfma_pkg::WIN_W'(2));
        send_frame(3);
        send_sample(random_sample(), 1'b0);
        send_sample(random_sample(), 1'b0);
        wait_drained();
        write_window(wfma_pkg::WIN_W'(3));
        send_sample(random_sample(), 1'b1);
        send_frame(3);
    endtask

    // long back-to-back stretch with no idling on either side
    task automatic test_long_frame();
        wait_drained();
        write_window(wfma_pkg::WIN_W'(3));
        calm_stretch = 1'b1;
        send_frame(wfma_pkg::FRAME_SAMPLES + 8);
        calm_stretch = 1'b0;
        send_frame(4);
        send_frame(4);
    endtask

    task automatic test_random_frames();
        int                         length;
        int                         odd_length;
        int                         budget;
        logic [wfma_pkg::WIN_W-1:0] setting;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: setting = wfma_pkg::WIN_W'(wfma_pkg::MAX_WINDOW);
                1: setting = wfma_pkg::WIN_W'(1);
                2: setting = '1;
                3: setting = '0;
                default: setting = wfma_pkg::WIN_W'($urandom_range(0, 31));
            endcase
            wait_drained();
            write_window(setting);
            calm_stretch = (phase == 4);
            length = $urandom_range(1, 6);
            budget = 0;
            while (budget < 12) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_frame(length);
                    budget += length;
                end else begin
                    odd_length = $urandom_range(1, 20);
                    send_frame(odd_length);
                    budget += odd_length;
                end
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, length)) send_sample(random_sample(), 1'b0);
        end
        calm_stretch = 1'b0;
    endtask

    initial begin
        foreach (frame_history[k])
            frame_history[k] = '0;
        foreach (position_sums[k])
            position_sums[k] = '0;
        held_frames    = 0;
        oldest_slot    = 0;
        next_position  = 0;
        window_setting = wfma_pkg::WIN_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_window();
        test_window_extremes();
        test_window_lowered();
        test_mid_frame_change();
        test_long_frame();
        test_random_frames();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
